/* hw/rtl/ste_pkg.sv */
// ste_pkg: shared types, constants and helpers for the sprite tile expander
// no dependencies; imported by ste_cell_seq and sprite_tile_expander
`default_nettype none

package ste_pkg;

    // position offsets applied before the 9-bit wrap
    localparam logic [8:0]  X_BIAS        = 9'd6;
    localparam logic [8:0]  Y_BIAS        = 9'd10;
    // one cell is 8 pixels on either axis
    localparam logic [8:0]  CELL_STEP     = 9'd8;
    // wrapped position is shown shifted left/up by 8
    localparam logic [9:0]  SCREEN_OFS    = 10'd8;
    // tile code advances by 64 per cell row
    localparam logic [11:0] TILE_ROW_STEP = 12'd64;
    localparam logic [11:0] TILE_COL_STEP = 12'd1;

    // register map (word index)
    typedef enum logic {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    // one cell draw command, before the visibility test
    typedef struct packed {
        logic [11:0]       tile_code;
        logic [3:0]        palette;
        logic signed [9:0] screen_x;
        logic signed [9:0] screen_y;
        logic              flip_x;
        logic              flip_y;
        logic [6:0]        priority_mask;
        logic              shadow;
        logic              last;
    } ste_cell_t;

    // (1 << level) - 1, kept to 7 bits
    function automatic logic [6:0] prio_mask(input logic [2:0] level);
        logic [7:0] m;
        m = (8'd1 << level) - 8'd1;
        return m[6:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ste_cell_seq.sv */
// ste_cell_seq: walks the cells of one sprite, one cell per advance
// uses ste_pkg; one shared tile adder and one shared +/-8 position stepper
`default_nettype none

module ste_cell_seq (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [15:0]        y_word,
    input  wire logic [15:0]        tile_word,
    input  wire logic [15:0]        attr_word,
    input  wire logic [15:0]        x_word,
    input  wire logic               advance,
    output logic                    busy,
    output ste_pkg::ste_cell_t      cmd
);
    import ste_pkg::*;

    logic       busy_reg, busy_next;
    logic [2:0] row_reg;
    logic [1:0] col_reg;
    logic [2:0] h_m1_reg;
    logic [1:0] w_m1_reg;
    logic       fx_reg, fy_reg, shadow_reg;
    logic [3:0] pal_reg;
    logic [6:0] pmask_reg;
    logic [11:0] tile_row_reg, tile_reg;
    logic [8:0] x_start_reg, x_reg, y_reg;

    logic       row_end, sprite_end, step;
    logic [8:0] pos_src, pos_res;
    logic       pos_dir;
    logic [11:0] tile_src, tile_inc, tile_res;
    logic [1:0] w_m1_in;
    logic [2:0] h_m1_in;
    logic       fx_in, fy_in;

    assign w_m1_in = attr_word[13:12];
    assign h_m1_in = y_word[14:12];
    assign fx_in   = attr_word[15];
    assign fy_in   = y_word[15];

    assign row_end    = (col_reg == w_m1_reg);
    assign sprite_end = row_end && (row_reg == h_m1_reg);
    assign step       = busy_reg && advance;

    // shared position stepper: y at a row end, x otherwise
    always_comb begin
        pos_src = row_end ? y_reg : x_reg;
        pos_dir = row_end ? fy_reg : fx_reg;
        pos_res = pos_dir ? (pos_src - CELL_STEP) : (pos_src + CELL_STEP);
    end

    // shared tile adder: next row base at a row end, next column otherwise
    always_comb begin
        tile_src = row_end ? tile_row_reg : tile_reg;
        tile_inc = row_end ? TILE_ROW_STEP : TILE_COL_STEP;
        tile_res = tile_src + tile_inc;
    end

    always_comb begin
        busy_next = busy_reg;
        if (start) begin
            busy_next = 1'b1;
        end else if (step && sprite_end) begin
            busy_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // sprite attributes and cell walk
    always_ff @(posedge aclk) begin
        if (start) begin
            w_m1_reg     <= w_m1_in;
            h_m1_reg     <= h_m1_in;
            fx_reg       <= fx_in;
            fy_reg       <= fy_in;
            shadow_reg   <= attr_word[14];
            pal_reg      <= attr_word[7:4];
            pmask_reg    <= prio_mask(attr_word[2:0]);
            row_reg      <= 3'd0;
            col_reg      <= 2'd0;
            tile_row_reg <= tile_word[11:0];
            tile_reg     <= tile_word[11:0];
            x_start_reg  <= x_word[8:0] + X_BIAS
                            + (fx_in ? {4'd0, w_m1_in, 3'd0} : 9'd0);
            x_reg        <= x_word[8:0] + X_BIAS
                            + (fx_in ? {4'd0, w_m1_in, 3'd0} : 9'd0);
            y_reg        <= y_word[8:0] + Y_BIAS
                            + (fy_in ? {3'd0, h_m1_in, 3'd0} : 9'd0);
        end else if (step && !sprite_end) begin
            if (row_end) begin
                row_reg      <= row_reg + 3'd1;
                col_reg      <= 2'd0;
                tile_row_reg <= tile_res;
                tile_reg     <= tile_res;
                x_reg        <= x_start_reg;
                y_reg        <= pos_res;
            end else begin
                col_reg  <= col_reg + 2'd1;
                tile_reg <= tile_res;
                x_reg    <= pos_res;
            end
        end
    end

    // current cell command
    always_comb begin
        cmd.tile_code     = tile_reg;
        cmd.palette       = pal_reg;
        cmd.screen_x      = {1'b0, x_reg} - SCREEN_OFS;
        cmd.screen_y      = {1'b0, y_reg} - SCREEN_OFS;
        cmd.flip_x        = fx_reg;
        cmd.flip_y        = fy_reg;
        cmd.priority_mask = pmask_reg;
        cmd.shadow        = shadow_reg;
        cmd.last          = sprite_end;
    end

    assign busy = busy_reg;

    // a new sprite always starts the walk
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("walk not running after start");

    // the walk only ends after the final cell was taken
    a_end_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> $past(advance && sprite_end))
        else $error("walk ended before final cell");

    // counters stay inside the sprite
    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (row_reg <= h_m1_reg) && (col_reg <= w_m1_reg))
        else $error("cell counter out of range");

    // tile code tracks row base plus column
    a_tile_track: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (tile_reg == tile_row_reg + {10'd0, col_reg}))
        else $error("tile code out of step with column");

endmodule

`default_nettype wire

/* hw/rtl/sprite_tile_expander.sv */
// sprite_tile_expander: top level, config registers, visibility test, output word
// uses ste_pkg and ste_cell_seq
//
// Usage: one sprite record enters on the s_ stream as a single 64-bit word
// (y_word, tile_word, attr_word, x_word from the low bits up). It expands into
// width*height cell words on the m_ stream, row by row and column by column,
// with m_tlast set on the final cell. A sprite is 1 to 4 cells wide and 1 to 8
// tall, so it yields 1 to 32 words.
// The first cell word of a record goes through the sequencer's cell registers
// and then the output register. Throughput: one cell word per cycle while
// m_tready is high; s_tready is low while a sprite is walked, so a new record is
// taken only after the walk ends. The cell sequencer steps one cell per cycle,
// unless paused, through its shared tile adder and position stepper.
// When m_tready is low the current word holds in the output register and the
// walk pauses; the next record is taken while the final word still waits.
// screen_width and screen_height sit at APB byte addresses 0 and 4 and should
// be written only while idle.
// Reset (aresetn low, synchronous) empties the output register, stops any walk
// and returns the screen size to 304 by 256.
`default_nettype none

module sprite_tile_expander (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // sprite record in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // y_word[15:0], tile_word[31:16], attr_word[47:32], x_word[63:48]
    input  wire logic [63:0] s_tdata,
    // cell command out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tile_code[11:0], palette[15:12], screen_x[25:16], screen_y[35:26],
    // flip_x[36], flip_y[37], priority_mask[44:38], shadow[45], visible[46]
    output logic [47:0]      m_tdata,
    output logic             m_tlast
);
    import ste_pkg::*;

    logic [9:0]  width_reg, height_reg;
    logic        cfg_write;
    logic        start, busy, advance;
    ste_cell_t   cmd;
    logic signed [10:0] sx_ext, sy_ext, w_ext, h_ext;
    logic        visible;
    logic        m_valid_reg;
    logic [47:0] m_data_reg;
    logic        m_last_reg;

    // apb write and read
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 10'd304;
            height_reg <= 10'd256;
        end else if (cfg_write) begin
            case (cfg_reg_t'(paddr[2]))
                CFG_SCREEN_WIDTH:  width_reg  <= pwdata[9:0];
                CFG_SCREEN_HEIGHT: height_reg <= pwdata[9:0];
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg_t'(paddr[2]))
            CFG_SCREEN_WIDTH:  prdata = {22'd0, width_reg};
            CFG_SCREEN_HEIGHT: prdata = {22'd0, height_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // input handshake
    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;
    assign advance  = busy && (!m_valid_reg || m_tready);

    ste_cell_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .y_word    (s_tdata[15:0]),
        .tile_word (s_tdata[31:16]),
        .attr_word (s_tdata[47:32]),
        .x_word    (s_tdata[63:48]),
        .advance   (advance),
        .busy      (busy),
        .cmd       (cmd)
    );

    // all-or-nothing visibility against the screen size
    always_comb begin
        sx_ext  = {cmd.screen_x[9], cmd.screen_x};
        sy_ext  = {cmd.screen_y[9], cmd.screen_y};
        w_ext   = {1'b0, width_reg};
        h_ext   = {1'b0, height_reg};
        visible = (sx_ext > -11'sd8) && (sy_ext > -11'sd8)
                  && (sx_ext < w_ext) && (sy_ext < h_ext);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {1'b0, visible, cmd.shadow, cmd.priority_mask,
                           cmd.flip_y, cmd.flip_x, cmd.screen_y, cmd.screen_x,
                           cmd.palette, cmd.tile_code};
            m_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
